// ----- hw/rtl/sisul_pkg.sv -----
// Shared types and constants for the stable index sorter.
// The cell and the top level both import this package; it has no dependencies.
package sisul_pkg;

   localparam int DEF_MAX_ENTRIES = 64;
   localparam int KEY_W           = 64;
   localparam int INDEX_W         = 6;

   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } sisul_state_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [INDEX_W-1:0]      idx;
   } sisul_entry_type;

   typedef struct packed {
      logic            insert;
      logic            shift;
      sisul_entry_type entry;
   } sisul_ctrl_type;

   function automatic logic signed [KEY_W-1:0] map_key(input logic signed [KEY_W-1:0] raw);
      logic signed [KEY_W-1:0] mapped;
      mapped = raw[KEY_W-1] ? KEY_MAX : raw;
      return mapped;
   endfunction

endpackage

// ----- hw/rtl/sisul_cell.sv -----
// One cell of the insertion chain: holds one key and its arrival index.
// Depends on sisul_pkg for the entry and control types.
module sisul_cell
   import sisul_pkg::*;
(
   input  logic            clock,
   input  sisul_ctrl_type  ctrl,
   input  logic            occupied,
   input  logic            left_gt,
   input  sisul_entry_type left_entry,
   input  sisul_entry_type right_entry,
   output sisul_entry_type entry,
   output logic            gt
);

   sisul_entry_type entry_ff;
   sisul_entry_type entry_in;

   // An empty cell counts as greater than any key, so the new item lands there.
   assign gt = !occupied || (entry_ff.key > ctrl.entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt) begin
            entry_in = ctrl.entry;
         end
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- hw/rtl/stable_index_sort_unstamped_last.sv -----
// Top level of the stable index sorter: a chain of insertion cells and the output stage.
// Depends on sisul_pkg and sisul_cell.
//
//   channel | direction | ports                                  | item
//   req     | in        | req_valid req_stall req_anchor_key ... | one key of a list
//   rsp     | out       | rsp_valid rsp_stall rsp_entry_index ...| one index in sorted order
//
// While loading, every cell compares its key against the new one in parallel.
// During emission the chain shifts one stored entry toward cell zero on each pop.
// While a list is being emitted req_stall is high; the next list may load meanwhile the last
// result waits. A stall on rsp holds the output register and, during emission, freezes the chain.
// Reset clears the control state only; the cell contents are written before they are read.
module stable_index_sort_unstamped_last
   import sisul_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [KEY_W-1:0] req_anchor_key,
   input  logic                    req_list_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [INDEX_W-1:0]      rsp_entry_index,
   output logic                    rsp_final_result,
   output logic                    rsp_truncated
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   sisul_state_type    state_ff, state_in;
   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic               overflow_ff, overflow_in;
   logic               trunc_ff, trunc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_final_ff, rsp_final_in;
   logic               rsp_trunc_ff, rsp_trunc_in;

   logic               req_accept;
   logic               full;
   logic               store;
   logic               pop;
   sisul_ctrl_type     ctrl;
   sisul_entry_type    chain_entry [MAX_ENTRIES];
   logic               chain_gt    [MAX_ENTRIES];

   assign req_accept = req_valid && !req_stall;
   assign full       = (entry_count_ff == CNT_W'(MAX_ENTRIES));
   assign store      = req_accept && !full;
   assign pop        = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.insert    = store;
   assign ctrl.shift     = pop;
   assign ctrl.entry.key = map_key(req_anchor_key);
   assign ctrl.entry.idx = INDEX_W'(entry_count_ff);

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic            left_gt;
      sisul_entry_type left_entry;
      sisul_entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_entry = chain_entry[i];
      end else begin : g_body
         assign left_gt    = chain_gt[i-1];
         assign left_entry = chain_entry[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign right_entry = chain_entry[i];
      end else begin : g_inner
         assign right_entry = chain_entry[i+1];
      end

      sisul_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_W'(i) < entry_count_ff),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (chain_entry[i]),
         .gt          (chain_gt[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      overflow_in    = overflow_ff;
      trunc_in       = trunc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_final_in   = rsp_final_ff;
      rsp_trunc_in   = rsp_trunc_ff;
      req_stall      = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_accept) begin
               if (store) begin
                  entry_count_in = entry_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_list_end) begin
                  trunc_in    = overflow_ff || full;
                  overflow_in = 1'b0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (pop) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = chain_entry[0].idx;
               rsp_final_in   = (entry_count_ff == CNT_W'(1));
               rsp_trunc_in   = trunc_ff;
               entry_count_in = entry_count_ff - 1'b1;
               if (entry_count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         entry_count_ff <= '0;
         overflow_ff    <= 1'b0;
         trunc_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         overflow_ff    <= overflow_in;
         trunc_ff       <= trunc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_final_ff <= rsp_final_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_truncated    = rsp_trunc_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("Entry count exceeds the chain length.");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> entry_count_ff != '0)
      else $error("Emission running with an empty chain.");

   a_final_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (pop && entry_count_ff == CNT_W'(1)) |=> (state_ff == ST_LOAD && rsp_final_ff))
      else $error("Last pop did not end emission with the final flag.");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      (store && !req_list_end) |=> entry_count_ff == $past(entry_count_ff) + 1'b1)
      else $error("Stored item did not advance the entry count.");

endmodule
